### rtl/sfdp_pkg.sv
// Shared types, constants and decode tables for the SFDP basic table parser.
`timescale 1ns / 1ps

package sfdp_pkg;

    localparam int STORE_WORDS = 64;
    localparam int AW          = $clog2(STORE_WORDS);
    localparam int CW          = $clog2(STORE_WORDS + 1);
    localparam int IDX_W       = 23;

    localparam logic [31:0] SIG_WORD = 32'h5044_4653;
    localparam logic [31:0] HDR_MASK = 32'h00ff_00ff;
    localparam logic [31:0] HDR_ID   = 32'h0001_0000;

    localparam logic [1:0]  DEF_AMODE = 2'd0;
    localparam logic [7:0]  DEF_CHIP  = 8'd24;
    localparam logic [2:0]  DEF_LANE  = 3'd0;
    localparam logic [7:0]  DEF_RCMD  = 8'h03;
    localparam logic [7:0]  DEF_ECMD  = 8'hd8;
    localparam logic [7:0]  DEF_ESIZE = 8'd16;
    localparam logic [19:0] DEF_BLKTO = 20'd1000;
    localparam logic [25:0] DEF_CHPTO = 26'd60000;
    localparam logic [3:0]  DEF_PAGE  = 4'd8;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SIG,
        ST_REV,
        ST_H0,
        ST_H1,
        ST_W0,
        ST_W1,
        ST_RCHK,
        ST_RSEL,
        ST_E7,
        ST_E8,
        ST_B9,
        ST_BM1,
        ST_BM2,
        ST_C9,
        ST_C10,
        ST_CM1,
        ST_CM2,
        ST_DONE
    } step_t;

    typedef struct packed {
        step_t step;
        logic  rd;
        logic  use_data;
        logic  init;
        logic  finish;
    } cmd_t;

    typedef struct packed {
        logic fail;
        logic hdr_last;
        logic rm_zero;
        logic chk_skip;
        logic chk_hit;
        logic tlen9;
        logic tlen10;
        logic tlen11;
        logic best_nz;
    } stat_t;

    // read modes 1..6: check word offset, check bit, parameter word offset and field shifts
    function automatic logic [2:0] chk_off(input logic [2:0] rm);
        logic [2:0] r;
        case (rm)
            3'd5, 3'd6: r = 3'd4;
            default:    r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] chk_bit(input logic [2:0] rm);
        logic [4:0] r;
        case (rm)
            3'd1:    r = 5'd16;
            3'd2:    r = 5'd20;
            3'd3:    r = 5'd22;
            3'd4:    r = 5'd21;
            3'd6:    r = 5'd4;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] sel_word(input logic [2:0] rm);
        logic [2:0] r;
        case (rm)
            3'd1, 3'd2: r = 3'd3;
            3'd3, 3'd4: r = 3'd2;
            3'd5:       r = 3'd5;
            3'd6:       r = 3'd6;
            default:    r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] op_shift(input logic [2:0] rm);
        logic [4:0] r;
        case (rm)
            3'd1, 3'd4: r = 5'd8;
            default:    r = 5'd24;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] dum_shift(input logic [2:0] rm);
        logic [4:0] r;
        case (rm)
            3'd1, 3'd4: r = 5'd0;
            default:    r = 5'd16;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] mode_shift(input logic [2:0] rm);
        logic [4:0] r;
        case (rm)
            3'd1, 3'd4: r = 5'd5;
            default:    r = 5'd21;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] time_shift(input logic [1:0] et);
        logic [4:0] r;
        case (et)
            2'd0:    r = 5'd4;
            2'd1:    r = 5'd11;
            2'd2:    r = 5'd18;
            default: r = 5'd25;
        endcase
        return r;
    endfunction

    function automatic logic [9:0] block_unit(input logic [1:0] u);
        logic [9:0] r;
        case (u)
            2'd0:    r = 10'd1;
            2'd1:    r = 10'd16;
            2'd2:    r = 10'd128;
            default: r = 10'd1000;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] chip_unit(input logic [1:0] u);
        logic [15:0] r;
        case (u)
            2'd0:    r = 16'd16;
            2'd1:    r = 16'd256;
            2'd2:    r = 16'd4000;
            default: r = 16'd64000;
        endcase
        return r;
    endfunction

endpackage

### rtl/sfdp_ctrl.sv
// Decode sequencer and channel handshake control for the SFDP parser.
`timescale 1ns / 1ps

module sfdp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sfdp_valid,
    input  logic            last_word,
    output logic            sfdp_stall,
    output logic            result_valid,
    input  logic            result_stall,
    output logic            wr_en,
    output sfdp_pkg::cmd_t  cmd,
    input  sfdp_pkg::stat_t stat
);
    import sfdp_pkg::*;

    step_t state_reg, state_next;
    logic  ph_reg, ph_next;
    logic  rv_reg, rv_next;
    step_t after_read, after_blk;

    assign sfdp_stall   = (state_reg != ST_IDLE) || (rv_reg && last_word);
    assign wr_en        = sfdp_valid && !sfdp_stall;
    assign result_valid = rv_reg;

    assign after_blk  = stat.tlen11 ? ST_C9 : ST_DONE;
    assign after_read = stat.tlen9 ? ST_E7 : after_blk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ph_reg    <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            rv_reg    <= rv_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ph_next      = ph_reg;
        rv_next      = rv_reg && result_stall;
        cmd.step     = state_reg;
        cmd.rd       = 1'b0;
        cmd.use_data = 1'b0;
        cmd.init     = 1'b0;
        cmd.finish   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ph_next = 1'b0;
                if (wr_en && last_word)
                begin
                    cmd.init   = 1'b1;
                    state_next = ST_SIG;
                end
            end
            ST_RCHK:
            begin
                if (!ph_reg)
                begin
                    if (stat.rm_zero)
                    begin
                        state_next = after_read;
                    end
                    else if (!stat.chk_skip)
                    begin
                        cmd.rd  = 1'b1;
                        ph_next = 1'b1;
                    end
                end
                else
                begin
                    cmd.use_data = 1'b1;
                    ph_next      = 1'b0;
                    state_next   = stat.chk_hit ? ST_RSEL : ST_RCHK;
                end
            end
            ST_BM1: state_next = ST_BM2;
            ST_BM2: state_next = after_blk;
            ST_CM1: state_next = ST_CM2;
            ST_CM2: state_next = ST_DONE;
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                rv_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                // one word read, then its data is used
                if (!ph_reg)
                begin
                    cmd.rd  = 1'b1;
                    ph_next = 1'b1;
                end
                else
                begin
                    cmd.use_data = 1'b1;
                    ph_next      = 1'b0;
                    case (state_reg)
                        ST_SIG:  state_next = stat.fail ? ST_DONE : ST_REV;
                        ST_REV:  state_next = stat.fail ? ST_DONE : ST_H0;
                        ST_H0:   state_next = ST_H1;
                        ST_H1:
                        begin
                            if (stat.fail)
                                state_next = ST_DONE;
                            else
                                state_next = stat.hdr_last ? ST_W0 : ST_H0;
                        end
                        ST_W0:   state_next = ST_W1;
                        ST_W1:   state_next = stat.fail ? ST_DONE : ST_RCHK;
                        ST_RSEL: state_next = after_read;
                        ST_E7:   state_next = ST_E8;
                        ST_E8:   state_next = (stat.best_nz && stat.tlen10) ? ST_B9 : after_blk;
                        ST_B9:   state_next = ST_BM1;
                        ST_C9:   state_next = ST_C10;
                        ST_C10:  state_next = ST_CM1;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
        endcase
    end

endmodule

### rtl/sfdp_dpath.sv
// Word store, field decode and result registers for the SFDP parser.
`timescale 1ns / 1ps

module sfdp_dpath (
    input  logic             clk,
    input  logic             rst_n,
    input  sfdp_pkg::cmd_t   cmd,
    output sfdp_pkg::stat_t  stat,
    input  logic             allow_quad,
    input  logic             wr_en,
    input  logic [31:0]      wr_data,
    output logic             parse_status,
    output logic [1:0]       address_mode,
    output logic [7:0]       log2_chip_bytes,
    output logic [2:0]       read_lane_mode,
    output logic [7:0]       read_command,
    output logic [4:0]       read_dummy_cycles,
    output logic [2:0]       read_mode_clocks,
    output logic [7:0]       erase_command,
    output logic [7:0]       log2_erase_bytes,
    output logic [19:0]      block_erase_timeout_ms,
    output logic [25:0]      chip_erase_timeout_ms,
    output logic [3:0]       log2_page_bytes
);
    import sfdp_pkg::*;

    logic [31:0] mem [STORE_WORDS];
    logic [31:0] rdat_reg;
    logic        badnow_reg;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          bad_reg, bad_next;
    logic          err_reg, err_next;
    logic          status_reg, status_next;
    logic          found_reg, found_next;
    logic [7:0]    hi_reg, hi_next;
    logic [7:0]    nhm_reg, nhm_next;
    logic [31:0]   h0_reg, h0_next;
    logic [7:0]    tlen_reg, tlen_next;
    logic [21:0]   tbase_reg, tbase_next;
    logic [2:0]    rm_reg, rm_next;
    logic [1:0]    amode_reg, amode_next;
    logic [7:0]    chip_reg, chip_next;
    logic [2:0]    lane_reg, lane_next;
    logic [7:0]    rcmd_reg, rcmd_next;
    logic [4:0]    dummy_reg, dummy_next;
    logic [2:0]    mclk_reg, mclk_next;
    logic [7:0]    best_reg, best_next;
    logic [7:0]    eop_reg, eop_next;
    logic [1:0]    etype_reg, etype_next;
    logic [5:0]    mul_reg, mul_next;
    logic [1:0]    usel_reg, usel_next;
    logic [4:0]    ucnt_reg, ucnt_next;
    logic [10:0]   prod_reg, prod_next;
    logic [19:0]   blk_reg, blk_next;
    logic [25:0]   chpto_reg, chpto_next;
    logic [3:0]    page_reg, page_next;

    logic [IDX_W-1:0] addr, tb;
    logic [31:0]      d, tw;
    logic [4:0]       msb;
    logic [30:0]      lb;
    logic             szerr;
    logic [7:0]       sz_hi, sz_lo;
    logic             fail_now;

    assign tb = IDX_W'(tbase_reg);
    assign d  = badnow_reg ? 32'd0 : rdat_reg;
    assign lb = d[30:0];

    always_comb
    begin
        case (cmd.step)
            ST_SIG:        addr = '0;
            ST_REV:        addr = IDX_W'(1);
            ST_H0:         addr = IDX_W'({hi_reg, 1'b0}) + IDX_W'(2);
            ST_H1:         addr = IDX_W'({hi_reg, 1'b0}) + IDX_W'(3);
            ST_W0:         addr = tb;
            ST_W1:         addr = tb + IDX_W'(1);
            ST_RCHK:       addr = tb + IDX_W'(chk_off(rm_reg));
            ST_RSEL:       addr = tb + IDX_W'(sel_word(rm_reg));
            ST_E7:         addr = tb + IDX_W'(7);
            ST_E8:         addr = tb + IDX_W'(8);
            ST_B9, ST_C9:  addr = tb + IDX_W'(9);
            ST_C10:        addr = tb + IDX_W'(10);
            default:       addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (cnt_reg < CW'(STORE_WORDS)))
            mem[cnt_reg[AW-1:0]] <= wr_data;
        if (cmd.rd)
            rdat_reg <= mem[addr[AW-1:0]];
    end

    always_comb
    begin
        msb = 5'd0;
        for (int k = 0; k < 32; k++)
        begin
            if (d[k])
                msb = 5'(k);
        end
    end

    assign szerr = d[31] ? ((lb < 31'd3) || (lb > 31'd258)) : (d < 32'd8);

    assign sz_lo = (cmd.step == ST_E7) ? d[7:0]   : d[7:0];
    assign sz_hi = d[23:16];
    assign tw    = d >> time_shift(etype_reg);

    always_comb
    begin
        cnt_next    = cnt_reg;
        bad_next    = bad_reg;
        err_next    = err_reg;
        status_next = status_reg;
        found_next  = found_reg;
        hi_next     = hi_reg;
        nhm_next    = nhm_reg;
        h0_next     = h0_reg;
        tlen_next   = tlen_reg;
        tbase_next  = tbase_reg;
        rm_next     = rm_reg;
        amode_next  = amode_reg;
        chip_next   = chip_reg;
        lane_next   = lane_reg;
        rcmd_next   = rcmd_reg;
        dummy_next  = dummy_reg;
        mclk_next   = mclk_reg;
        best_next   = best_reg;
        eop_next    = eop_reg;
        etype_next  = etype_reg;
        mul_next    = mul_reg;
        usel_next   = usel_reg;
        ucnt_next   = ucnt_reg;
        prod_next   = prod_reg;
        blk_next    = blk_reg;
        chpto_next  = chpto_reg;
        page_next   = page_reg;
        fail_now    = 1'b0;

        if (wr_en && (cnt_reg < CW'(STORE_WORDS)))
            cnt_next = cnt_reg + CW'(1);

        if (cmd.use_data)
        begin
            bad_next = bad_reg | badnow_reg;
            case (cmd.step)
                ST_SIG: fail_now = (d != SIG_WORD);
                ST_REV:
                begin
                    fail_now = badnow_reg || (d[15:8] != 8'd1);
                    nhm_next = d[23:16];
                    hi_next  = 8'd0;
                end
                ST_H0: h0_next = d;
                ST_H1:
                begin
                    if (((h0_reg & HDR_MASK) == HDR_ID) && (d[31:24] == 8'hff))
                    begin
                        tlen_next  = h0_reg[31:24];
                        tbase_next = d[23:2];
                        found_next = 1'b1;
                    end
                    hi_next  = hi_reg + 8'd1;
                    fail_now = bad_reg || badnow_reg ||
                               ((hi_reg == nhm_reg) && (!found_next || (tlen_next < 8'd2)));
                end
                ST_W0: amode_next = (d[18:17] == 2'd3) ? 2'd0 : d[18:17];
                ST_W1:
                begin
                    fail_now  = bad_reg || badnow_reg || szerr;
                    chip_next = d[31] ? 8'(lb - 31'd3) : 8'(msb - 5'd2);
                    rm_next   = allow_quad ? 3'd6 : 3'd4;
                end
                ST_RCHK:
                begin
                    if (!d[chk_bit(rm_reg)])
                        rm_next = rm_reg - 3'd1;
                end
                ST_RSEL:
                begin
                    lane_next  = rm_reg;
                    rcmd_next  = 8'(d >> op_shift(rm_reg));
                    dummy_next = 5'(d >> dum_shift(rm_reg));
                    mclk_next  = 3'(d >> mode_shift(rm_reg));
                end
                ST_E7, ST_E8:
                begin
                    if (sz_lo > best_reg)
                    begin
                        best_next  = sz_lo;
                        eop_next   = d[15:8];
                        etype_next = (cmd.step == ST_E7) ? 2'd0 : 2'd2;
                    end
                    if (sz_hi > best_next)
                    begin
                        best_next  = sz_hi;
                        eop_next   = d[31:24];
                        etype_next = (cmd.step == ST_E7) ? 2'd1 : 2'd3;
                    end
                end
                ST_B9:
                begin
                    mul_next  = {1'b0, d[3:0], 1'b0} + 6'd2;
                    usel_next = tw[6:5];
                    ucnt_next = tw[4:0];
                end
                ST_C9: mul_next = {1'b0, d[3:0], 1'b0} + 6'd2;
                ST_C10:
                begin
                    usel_next = d[30:29];
                    ucnt_next = d[28:24];
                    page_next = d[7:4];
                end
                default: ;
            endcase
        end
        else if ((cmd.step == ST_RCHK) && !cmd.rd && (rm_reg != 3'd0))
        begin
            rm_next = rm_reg - 3'd1;
        end

        case (cmd.step)
            ST_BM1, ST_CM1: prod_next = 11'(mul_reg * ucnt_reg);
            ST_BM2:         blk_next = 20'(prod_reg * block_unit(usel_reg));
            ST_CM2:         chpto_next = 26'(prod_reg * chip_unit(usel_reg));
            default: ;
        endcase

        err_next = err_reg | fail_now;

        if (cmd.init)
        begin
            bad_next   = 1'b0;
            err_next   = 1'b0;
            found_next = 1'b0;
            amode_next = DEF_AMODE;
            chip_next  = DEF_CHIP;
            lane_next  = DEF_LANE;
            rcmd_next  = DEF_RCMD;
            dummy_next = 5'd0;
            mclk_next  = 3'd0;
            best_next  = 8'd0;
            blk_next   = DEF_BLKTO;
            chpto_next = DEF_CHPTO;
            page_next  = DEF_PAGE;
        end

        if (cmd.finish)
        begin
            status_next = err_reg | bad_reg;
            cnt_next    = '0;
        end
    end

    assign stat.fail     = fail_now;
    assign stat.hdr_last = (hi_reg == nhm_reg);
    assign stat.rm_zero  = (rm_reg == 3'd0);
    assign stat.chk_skip = (8'(chk_off(rm_reg)) >= tlen_reg);
    assign stat.chk_hit  = d[chk_bit(rm_reg)];
    assign stat.tlen9    = (tlen_reg >= 8'd9);
    assign stat.tlen10   = (tlen_reg >= 8'd10);
    assign stat.tlen11   = (tlen_reg >= 8'd11);
    assign stat.best_nz  = (best_next != 8'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            bad_reg    <= 1'b0;
            err_reg    <= 1'b0;
            status_reg <= 1'b0;
            found_reg  <= 1'b0;
            badnow_reg <= 1'b0;
            hi_reg     <= 8'd0;
            nhm_reg    <= 8'd0;
            rm_reg     <= 3'd0;
            etype_reg  <= 2'd0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            bad_reg    <= bad_next;
            err_reg    <= err_next;
            status_reg <= status_next;
            found_reg  <= found_next;
            hi_reg     <= hi_next;
            nhm_reg    <= nhm_next;
            rm_reg     <= rm_next;
            etype_reg  <= etype_next;
            if (cmd.rd)
                badnow_reg <= (addr >= IDX_W'(cnt_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        h0_reg    <= h0_next;
        tlen_reg  <= tlen_next;
        tbase_reg <= tbase_next;
        amode_reg <= amode_next;
        chip_reg  <= chip_next;
        lane_reg  <= lane_next;
        rcmd_reg  <= rcmd_next;
        dummy_reg <= dummy_next;
        mclk_reg  <= mclk_next;
        best_reg  <= best_next;
        eop_reg   <= eop_next;
        mul_reg   <= mul_next;
        usel_reg  <= usel_next;
        ucnt_reg  <= ucnt_next;
        prod_reg  <= prod_next;
        blk_reg   <= blk_next;
        chpto_reg <= chpto_next;
        page_reg  <= page_next;
    end

    // invalid table: every field shows its default
    always_comb
    begin
        parse_status           = status_reg;
        address_mode           = DEF_AMODE;
        log2_chip_bytes        = DEF_CHIP;
        read_lane_mode         = DEF_LANE;
        read_command           = DEF_RCMD;
        read_dummy_cycles      = 5'd0;
        read_mode_clocks       = 3'd0;
        erase_command          = DEF_ECMD;
        log2_erase_bytes       = DEF_ESIZE;
        block_erase_timeout_ms = DEF_BLKTO;
        chip_erase_timeout_ms  = DEF_CHPTO;
        log2_page_bytes        = DEF_PAGE;
        if (!status_reg)
        begin
            address_mode           = amode_reg;
            log2_chip_bytes        = chip_reg;
            read_lane_mode         = lane_reg;
            read_command           = rcmd_reg;
            read_dummy_cycles      = dummy_reg;
            read_mode_clocks       = mclk_reg;
            block_erase_timeout_ms = blk_reg;
            chip_erase_timeout_ms  = chpto_reg;
            log2_page_bytes        = page_reg;
            if (best_reg != 8'd0)
            begin
                erase_command    = eop_reg;
                log2_erase_bytes = best_reg;
            end
        end
    end

endmodule

### rtl/sfdp_flash_parameter_discovery_top.sv
// Top level of the SFDP basic parameter table parser.
`timescale 1ns / 1ps

// Each SFDP word accepted while sfdp_stall is low is written to a 64-word store; words past the
// store are dropped. The word flagged last_word starts decoding, which reads the store
// through its single registered port, with a read step and then a use step per word: first
// the signature, revision and headers up to the table, then read mode, erase and timing fields
// (each timeout also goes through its multiply states). Input is held off during decoding and
// while a result waits if the next word is a last word. One result follows each last word.
module sfdp_flash_parameter_discovery_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        sfdp_valid,
    output logic        sfdp_stall,
    input  logic [31:0] sfdp_word,
    input  logic        last_word,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        parse_status,
    output logic [1:0]  address_mode,
    output logic [7:0]  log2_chip_bytes,
    output logic [2:0]  read_lane_mode,
    output logic [7:0]  read_command,
    output logic [4:0]  read_dummy_cycles,
    output logic [2:0]  read_mode_clocks,
    output logic [7:0]  erase_command,
    output logic [7:0]  log2_erase_bytes,
    output logic [19:0] block_erase_timeout_ms,
    output logic [25:0] chip_erase_timeout_ms,
    output logic [3:0]  log2_page_bytes
);
    import sfdp_pkg::*;

    logic  allow_quad_reg;
    logic  wr_en;
    cmd_t  cmd;
    stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            allow_quad_reg <= 1'b0;
        else if (cfg_we)
            allow_quad_reg <= cfg_wdata;
    end

    sfdp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sfdp_valid   (sfdp_valid),
        .last_word    (last_word),
        .sfdp_stall   (sfdp_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .wr_en        (wr_en),
        .cmd          (cmd),
        .stat         (stat)
    );

    sfdp_dpath u_dpath (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cmd                    (cmd),
        .stat                   (stat),
        .allow_quad             (allow_quad_reg),
        .wr_en                  (wr_en),
        .wr_data                (sfdp_word),
        .parse_status           (parse_status),
        .address_mode           (address_mode),
        .log2_chip_bytes        (log2_chip_bytes),
        .read_lane_mode         (read_lane_mode),
        .read_command           (read_command),
        .read_dummy_cycles      (read_dummy_cycles),
        .read_mode_clocks       (read_mode_clocks),
        .erase_command          (erase_command),
        .log2_erase_bytes       (log2_erase_bytes),
        .block_erase_timeout_ms (block_erase_timeout_ms),
        .chip_erase_timeout_ms  (chip_erase_timeout_ms),
        .log2_page_bytes        (log2_page_bytes)
    );

endmodule

### rtl/sfdp_chk.sv
// Port-level assertion checker for the SFDP parser, bound to the top level.
`timescale 1ns / 1ps

module sfdp_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        sfdp_valid,
    input logic        sfdp_stall,
    input logic        last_word,
    input logic        result_valid,
    input logic        result_stall,
    input logic        parse_status,
    input logic [1:0]  address_mode,
    input logic [2:0]  read_lane_mode,
    input logic [7:0]  read_command,
    input logic [7:0]  erase_command,
    input logic [3:0]  log2_page_bytes
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall |=> !result_valid)
        else $error("second result right after a transfer");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sfdp_valid && !sfdp_stall && last_word |=> sfdp_stall && !result_valid)
        else $error("decode did not hold off input");

    a_defaults: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && parse_status |-> address_mode == 2'd0 && read_command == 8'h03 &&
            erase_command == 8'hd8 && log2_page_bytes == 4'd8)
        else $error("invalid result without defaults");

    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> address_mode != 2'd3 && read_lane_mode != 3'd7)
        else $error("reserved code in result");

endmodule

bind sfdp_flash_parameter_discovery_top sfdp_chk u_sfdp_chk (.*);
